>>> rtl/adff_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Advertising flags discovery filter package
// Shared types and constants for the report parser, its word registers and
// the top level.
// ----------------------------------------------------------------------------
package adff_pkg;

   localparam logic [7:0] AD_TYPE_FLAGS     = 8'h01;
   localparam int unsigned FLAG_LIMITED_BIT = 0;
   localparam int unsigned FLAG_GENERAL_BIT = 1;
   localparam logic [7:0] MIN_FLAGS_LENGTH  = 8'd2;

   typedef enum logic [1:0] {
      PH_LEN  = 2'd0,
      PH_TYPE = 2'd1,
      PH_VAL  = 2'd2,
      PH_STOP = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      MODE_NONE    = 2'd0,
      MODE_LIMITED = 2'd1,
      MODE_GENERAL = 2'd2,
      MODE_UNKNOWN = 2'd3
   } mode_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       empty_report;
   } in_word_type;

   typedef struct packed {
      logic       status;
      logic [7:0] flags_value;
      logic       flags_found;
      logic       accept;
   } rsp_word_type;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] bytes_left;
      logic       struct_is_flags;
      logic [7:0] candidate_flags;
      logic       have_flags;
      logic [7:0] found_flags;
   } parse_state_type;

   localparam parse_state_type PARSE_CLEAR = '{
      phase:           PH_LEN,
      bytes_left:      8'd0,
      struct_is_flags: 1'b0,
      candidate_flags: 8'd0,
      have_flags:      1'b0,
      found_flags:     8'd0
   };

endpackage : adff_pkg
`default_nettype wire

>>> rtl/adv_flags_discovery_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Advertising flags discovery filter
// Filters advertising reports by the flags structure and the discovery mode.
// ----------------------------------------------------------------------------
// The req_ channel carries one report byte per word, with req_tlast on the
// final byte and req_tuser set for a word that ends the report without a
// byte. The rsp_ channel carries one decision word per report. The csr_
// port writes the two-bit discovery mode; the user writes it only while the
// block is idle, which the block does not enforce. A word is taken into an
// input register and parsed there; a report's decision is registered when
// its ending word advances. One word per cycle is taken unless an ending
// word is stalled; the rate is set by the single parse step between the
// input and result registers. Reset empties both registers, clears the
// parse state and sets the mode to accept all. While a decision waits on
// a low rsp_tready, bytes that do not end a report still flow; a word that
// ends the next report waits in the input register and req_tready drops.
// ----------------------------------------------------------------------------
module adv_flags_discovery_filter (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // data_byte
   input  wire         req_tlast,   // last_byte
   input  wire         req_tuser,   // empty_report
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // accept, flags_found, flags_value[7:0], status, zeros
   input  wire         csr_we,
   input  wire  [1:0]  csr_wdata
);
   import adff_pkg::*;

   mode_type     mode_ff;
   in_word_type  req_word;
   in_word_type  s1_word;
   logic         s1_valid;
   logic         s1_advance;
   logic         emit;
   rsp_word_type result;
   rsp_word_type rsp_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NONE;
      end else if (csr_we) begin
         mode_ff <= mode_type'(csr_wdata);
      end
   end

   assign req_word.data_byte    = req_tdata;
   assign req_word.last_byte    = req_tlast;
   assign req_word.empty_report = req_tuser;

   assign s1_advance = s1_valid & (~emit | ~rsp_tvalid | rsp_tready);
   assign req_tready = ~s1_valid | s1_advance;

   adff_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (req_tvalid & req_tready),
      .load_word  (req_word),
      .consume    (s1_advance),
      .word_valid (s1_valid),
      .word       (s1_word)
   );

   adff_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .item      (s1_word),
      .item_fire (s1_advance),
      .mode      (mode_ff),
      .emit      (emit),
      .result    (result)
   );

   adff_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (s1_advance & emit),
      .load_word  (result),
      .take       (rsp_tready),
      .word_valid (rsp_tvalid),
      .word       (rsp_word)
   );

   assign rsp_tdata = {5'd0, rsp_word};

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      s1_valid && emit && rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("report end advanced into a stalled result register");

   a_flags_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> rsp_tdata[9:2] == 8'd0)
      else $error("flags value nonzero without flags");

   a_status_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10] |-> !rsp_tdata[0])
      else $error("error status on an accepted report");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule : adv_flags_discovery_filter
`default_nettype wire

>>> rtl/adff_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Input word register
// Holds one accepted input word until the parser consumes it.
// ----------------------------------------------------------------------------
module adff_in_reg (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  load,
   input  adff_pkg::in_word_type load_word,
   input  wire                  consume,
   output logic                 word_valid,
   output adff_pkg::in_word_type word
);
   import adff_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   in_word_type word_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= load_word;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule : adff_in_reg
`default_nettype wire

>>> rtl/adff_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Report parser
// Walks the length-type-value structures of a report one byte per word and
// forms the discovery decision at the end of the report.
// ----------------------------------------------------------------------------
module adff_parser (
   input  wire                   clock,
   input  wire                   reset,
   input  adff_pkg::in_word_type  item,
   input  wire                   item_fire,
   input  adff_pkg::mode_type     mode,
   output logic                  emit,
   output adff_pkg::rsp_word_type result
);
   import adff_pkg::*;

   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type tk;

   assign emit = item.empty_report | item.last_byte;

   always_comb begin
      tk = state_ff;
      if (!item.empty_report) begin
         case (state_ff.phase)
            PH_LEN: begin
               if (item.data_byte == 8'd0) begin
                  tk.phase = PH_STOP;
               end else begin
                  tk.bytes_left = item.data_byte;
                  tk.phase      = PH_TYPE;
               end
            end
            PH_TYPE: begin
               tk.struct_is_flags = (item.data_byte == AD_TYPE_FLAGS) &&
                                    !state_ff.have_flags &&
                                    (state_ff.bytes_left >= MIN_FLAGS_LENGTH);
               tk.bytes_left = state_ff.bytes_left - 8'd1;
               if (tk.bytes_left == 8'd0) begin
                  if (tk.struct_is_flags) begin
                     tk.found_flags     = tk.candidate_flags;
                     tk.struct_is_flags = 1'b0;
                  end
                  tk.phase = PH_LEN;
               end else begin
                  tk.phase = PH_VAL;
               end
            end
            PH_VAL: begin
               if (state_ff.struct_is_flags && !state_ff.have_flags) begin
                  tk.candidate_flags = item.data_byte;
                  tk.have_flags      = 1'b1;
               end
               tk.bytes_left = state_ff.bytes_left - 8'd1;
               if (tk.bytes_left == 8'd0) begin
                  if (tk.struct_is_flags) begin
                     tk.found_flags     = tk.candidate_flags;
                     tk.struct_is_flags = 1'b0;
                  end
                  tk.phase = PH_LEN;
               end
            end
            default: begin
            end
         endcase
      end
      state_in = emit ? PARSE_CLEAR : tk;
   end

   always_comb begin
      logic found;
      logic [7:0] fv;
      found  = tk.have_flags & ~tk.struct_is_flags;
      fv     = found ? tk.found_flags : 8'd0;
      result = '0;
      result.flags_found = found;
      result.flags_value = fv;
      case (mode)
         MODE_NONE: begin
            result.accept = 1'b1;
         end
         MODE_LIMITED: begin
            result.accept = found & fv[FLAG_LIMITED_BIT];
         end
         MODE_GENERAL: begin
            result.accept = found & (fv[FLAG_LIMITED_BIT] | fv[FLAG_GENERAL_BIT]);
         end
         MODE_UNKNOWN: begin
            result.status = found;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PARSE_CLEAR;
      end else if (item_fire) begin
         state_ff <= state_in;
      end
   end

endmodule : adff_parser
`default_nettype wire

>>> rtl/adff_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Result word register
// Holds one decision word until the receiver takes it.
// ----------------------------------------------------------------------------
module adff_out_reg (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   load,
   input  adff_pkg::rsp_word_type load_word,
   input  wire                   take,
   output logic                  word_valid,
   output adff_pkg::rsp_word_type word
);
   import adff_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= load_word;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule : adff_out_reg
`default_nettype wire
